// ----- design/sxf_pkg.sv -----
package sxf_pkg;

  // screen geometry
  localparam int SCREEN_COLS = 64;
  localparam int SCREEN_ROWS = 32;

  // stored row word, bit 63 is column 0
  localparam int FRAME_W  = 64;
  localparam int SPRITE_W = 8;
  localparam int COL_AW   = $clog2(SCREEN_COLS);
  localparam int ROW_AW   = $clog2(SCREEN_ROWS);
  // origin row plus sprite row offset (offset below 16)
  localparam int YW       = $clog2(SCREEN_ROWS + 16);

  // columns that exist on screen
  localparam logic [FRAME_W-1:0] COL_MASK = ~({FRAME_W{1'b1}} >> SCREEN_COLS);

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [7:0]          origin_x;
    logic [7:0]          origin_y;
    logic [3:0]          row_index;
    logic [SPRITE_W-1:0] sprite_byte;
    logic                last_row;
    logic [4:0]          read_line;
  } sxf_in_t;

  typedef struct packed {
    logic               collision;
    logic [FRAME_W-1:0] line_pixels;
    logic               sprite_done;
  } sxf_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic exec;
  } sxf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } sxf_stat_t;

endpackage

// ----- design/sxf_ctrl.sv -----
module sxf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sxf_pkg::sxf_stat_t  stat,
  output sxf_pkg::sxf_cmd_t   cmd
);
  import sxf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   in_stall_r;
  logic   accept;

  assign accept   = in_valid && !in_stall_r;
  assign in_stall = in_stall_r;

  assign cmd.capture = accept;
  assign cmd.mem_rd  = (state_r == S_FETCH);
  assign cmd.exec    = (state_r == S_EXEC) && !stat.out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r    <= S_FETCH;
            in_stall_r <= 1'b1;
          end else begin
            in_stall_r <= 1'b0;
          end
        end
        S_FETCH: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (!stat.out_busy) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_stall_r <= 1'b0;
        end
      endcase
    end
  end

  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_FETCH) && in_stall_r)
    else $error("accepted beat did not start a row fetch");

  a_fetch_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |=> (state_r == S_EXEC))
    else $error("row fetch not followed by execute");

  a_exec_release: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !in_stall_r)
    else $error("input still stalled after execute");

endmodule

// ----- design/sxf_dp.sv -----
module sxf_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sxf_pkg::sxf_in_t    in_data,
  input  sxf_pkg::sxf_cmd_t   cmd,
  output sxf_pkg::sxf_stat_t  stat,
  input  logic                out_stall,
  output logic                out_valid,
  output sxf_pkg::sxf_out_t   out_data
);
  import sxf_pkg::*;

  sxf_in_t              item_r;
  logic [FRAME_W-1:0]   mem [SCREEN_ROWS];
  logic [FRAME_W-1:0]   rd_data_r;
  logic [SCREEN_ROWS-1:0] row_valid_r;
  logic                 coll_r;
  logic                 coll_nxt;
  logic                 out_valid_r;
  sxf_out_t             out_data_r;
  sxf_out_t             out_data_nxt;

  logic [COL_AW-1:0]    col_x;
  logic [YW-1:0]        y_sum;
  logic [YW-1:0]        line_ext;
  logic                 y_in_range;
  logic                 line_in_range;
  logic [ROW_AW-1:0]    row_addr;
  logic [FRAME_W-1:0]   row_q;
  logic [FRAME_W-1:0]   pat;
  logic                 hit;
  logic                 is_clear;
  logic                 is_draw;
  logic                 is_read;
  logic                 mem_wr;

  always_comb begin
    is_clear      = (item_r.cmd == CMD_CLEAR);
    is_draw       = (item_r.cmd == CMD_DRAW);
    is_read       = (item_r.cmd == CMD_READ);
    // origin wraps: power-of-two screen, so the low bits are the remainder
    col_x         = item_r.origin_x[COL_AW-1:0];
    y_sum         = YW'(item_r.origin_y[ROW_AW-1:0]) + YW'(item_r.row_index);
    y_in_range    = y_sum < YW'(SCREEN_ROWS);
    line_ext      = YW'(item_r.read_line);
    line_in_range = line_ext < YW'(SCREEN_ROWS);
    row_addr      = is_read ? line_ext[ROW_AW-1:0] : y_sum[ROW_AW-1:0];
    // rows never written since the last clear read as blank
    row_q         = row_valid_r[row_addr] ? rd_data_r : '0;
    pat           = ({item_r.sprite_byte, {(FRAME_W-SPRITE_W){1'b0}}} >> col_x) & COL_MASK;
    hit           = |(row_q & pat);
    mem_wr        = cmd.exec && is_draw && y_in_range;

    coll_nxt = coll_r;
    if (is_draw) begin
      coll_nxt = ((item_r.row_index == 4'd0) ? 1'b0 : coll_r) | (y_in_range & hit);
    end

    out_data_nxt.collision   = coll_nxt;
    out_data_nxt.line_pixels = (is_read && line_in_range) ? row_q : '0;
    out_data_nxt.sprite_done = is_draw ? item_r.last_row : 1'b0;
  end

  assign stat.out_busy = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  // frame store
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_data_r <= mem[row_addr];
    end
    if (mem_wr) begin
      mem[row_addr] <= row_q ^ pat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      coll_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec && is_clear) begin
        row_valid_r <= '0;
      end else if (mem_wr) begin
        row_valid_r[row_addr] <= 1'b1;
      end
      if (cmd.exec) begin
        coll_r      <= coll_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_clear_blanks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && is_clear) |=> (row_valid_r == '0))
    else $error("clear left rows marked as written");

  a_offscreen_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && is_draw && !y_in_range && (item_r.row_index == 4'd0)) |=> !coll_r)
    else $error("collision not cleared on first sprite row");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.out_busy |-> !cmd.exec)
    else $error("result register overwritten while stalled");

endmodule

// ----- design/sprite_xor_framebuffer.sv -----
// sequence: the accepting edge registers the beat, the row fetch follows, then xor and
//   write back raise out_valid; the execute step waits while out_valid is held by out_stall
// input: a new beat is accepted only once the previous one has executed (row read-modify-write)
// reset: synchronous active-low rst_n; in_stall is high in reset and the cycle after;
//   the frame reads as all pixels off straight away (per-row written bits cleared in reset)
//   and the collision flag is zero
module sprite_xor_framebuffer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sxf_pkg::sxf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sxf_pkg::sxf_out_t out_data
);
  import sxf_pkg::*;

  // command and status between the sequencer and the row datapath
  sxf_cmd_t  cmd;
  sxf_stat_t stat;

  // sequencer: idle, fetch the addressed row, then execute into the output register
  sxf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: item register, frame store, xor pattern, collision flag, output beat
  sxf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
